[src/bnlf_pkg.sv]
// Shared types and constants for the binary neighbourhood lookup filter.
// Holds the payload structs, action codes, register indexes and sizes.
// Depends on nothing; every other source file imports it.
`timescale 1ns / 1ps
`default_nettype none

package bnlf_pkg;

	localparam int MAX_ROWS = 1024;
	localparam int MAX_COLS = 1024;

	// Row position addresses the column store; column position also reaches the
	// padding column, one past the last image column.
	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int COL_W = $clog2(MAX_COLS + 1);

	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 2;
	localparam int POS_W     = 10;

	localparam int RESET_ROWS = (MAX_ROWS < 1024) ? MAX_ROWS : 1024;
	localparam int RESET_COLS = (MAX_COLS < 1024) ? MAX_COLS : 1024;

	localparam int LUT_DEPTH = 512;
	localparam int LUT_AW    = $clog2(LUT_DEPTH);

	localparam int OBUF_DEPTH = 4;
	localparam int OBUF_AW    = $clog2(OBUF_DEPTH);
	localparam int OBUF_CW    = $clog2(OBUF_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_COLS = 2'd1;

	typedef enum logic [1:0] {
		ACT_LOAD  = 2'd0,
		ACT_PIXEL = 2'd1,
		ACT_PAD   = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef struct packed {
		action_t           action;
		logic              pixel_in;
		logic [LUT_AW-1:0] table_index;
		logic              table_value;
	} in_item_t;

	typedef struct packed {
		logic             pixel_out;
		logic [POS_W-1:0] out_row;
		logic [POS_W-1:0] out_col;
		logic             run_last;
	} out_item_t;

	// Up to two results enter the output buffer in one cycle.
	typedef struct packed {
		logic      a_en;
		out_item_t a;
		logic      b_en;
		out_item_t b;
	} push_t;

	typedef struct packed {
		logic              we;
		logic [LUT_AW-1:0] waddr;
		logic              wdata;
		logic              re;
		logic [LUT_AW-1:0] raddr_a;
		logic [LUT_AW-1:0] raddr_b;
	} lut_req_t;

	// Zero is taken as one; anything above the limit saturates to it.
	function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
			input logic [CFG_W-1:0] maxv);
		logic [CFG_W-1:0] r;
		priority if (v == '0) begin
			r = CFG_W'(1);
		end else if (v > maxv) begin
			r = maxv;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[src/bnlf_lut.sv]
// Lookup table memory: 512 one-bit entries, one write port, two read ports.
// Read data is registered. Uses bnlf_pkg for the request struct and sizes.
`timescale 1ns / 1ps
`default_nettype none

module bnlf_lut (
	input  logic               clk,
	input  bnlf_pkg::lut_req_t req,
	output logic               rdata_a,
	output logic               rdata_b
);
	import bnlf_pkg::*;

	logic lut_mem [LUT_DEPTH];
	logic rd_a_q;
	logic rd_b_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			lut_mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_a_q <= lut_mem[req.raddr_a];
			rd_b_q <= lut_mem[req.raddr_b];
		end
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;

endmodule

`default_nettype wire

[src/bnlf_obuf.sv]
// Output buffer: a four-slot queue that takes up to two results a cycle
// and hands one a cycle to the output channel while it is ready. Uses bnlf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bnlf_obuf (
	input  logic                clk,
	input  logic                arst_n,
	input  bnlf_pkg::push_t     push,
	output logic                room,
	output logic                out_valid,
	input  logic                out_ready,
	output bnlf_pkg::out_item_t out_data
);
	import bnlf_pkg::*;

	out_item_t          slot_q [OBUF_DEPTH];
	logic [OBUF_AW-1:0] wr_ptr_q;
	logic [OBUF_AW-1:0] rd_ptr_q;
	logic [OBUF_CW-1:0] count_q;
	logic [OBUF_AW-1:0] wr_ptr_b;
	logic [OBUF_CW-1:0] n_push;
	logic               pop;

	assign pop      = out_valid && out_ready;
	assign n_push   = OBUF_CW'(push.a_en) + OBUF_CW'(push.b_en);
	assign wr_ptr_b = push.a_en ? wr_ptr_q + OBUF_AW'(1) : wr_ptr_q;

	// The pipeline only moves while two slots are free, so a push never overflows.
	assign room      = count_q <= OBUF_CW'(OBUF_DEPTH - 2);
	assign out_valid = count_q != '0;
	assign out_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.a_en) begin
			slot_q[wr_ptr_q] <= push.a;
		end
		if (push.b_en) begin
			slot_q[wr_ptr_b] <= push.b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OBUF_AW'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OBUF_AW'(1);
			end
			count_q <= count_q + n_push - OBUF_CW'(pop);
		end
	end

endmodule

`default_nettype wire

[src/binary_neighbourhood_lut_filter.sv]
// Binary 3x3 neighbourhood lookup filter, top level.
// Throughput while the output buffer has room and the receiver is ready:
// one input transfer per cycle; at most two results per transfer, one out per cycle.
// The rate is set by the single read port of the column store, read once per pixel.
// Reset (arst_n low) clears positions, sizes (1024 x 1024) and the output buffer at once;
// the column store and the lookup table are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module binary_neighbourhood_lut_filter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  bnlf_pkg::in_item_t            in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output bnlf_pkg::out_item_t           out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bnlf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bnlf_pkg::CFG_W-1:0]     cfg_data
);
	import bnlf_pkg::*;

	// Pixels arrive column by column. For every row the column store keeps the
	// pixels of the two previous columns (bit 0 the previous column, bit 1 the one
	// before). A pixel item reads its own row's entry on transfer, and in the next
	// stage writes it back shifted, with the new pixel in bit 0. The entries of the
	// two rows above travel in a small window of registers, as do the pixels of the
	// current column at those rows, so one read a pixel covers the whole 3x3 window.

	logic pipe_en;
	logic in_fire;
	logic cfg_fire;
	logic cfg_hit;
	logic adv0;
	logic cur0;
	logic last0;

	// Frame geometry and position of the next stream item.
	logic [CFG_W-1:0] rows_q;
	logic [CFG_W-1:0] cols_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;

	// Stage one: column store read data is available.
	logic              adv_s1;
	logic              load_s1;
	logic              emit_a_s1;
	logic              emit_b_s1;
	logic              left_s1;
	logic              right_s1;
	logic              ge1_s1;
	logic              ge2_s1;
	logic              cur_s1;
	logic [ROW_W-1:0]  row_s1;
	logic [POS_W-1:0]  col_s1;
	logic [LUT_AW-1:0] tidx_s1;
	logic              tval_s1;

	// Stage two: table read data is available.
	logic             emit_a_s2;
	logic             emit_b_s2;
	logic [ROW_W-1:0] row_s2;
	logic [POS_W-1:0] col_s2;

	logic [1:0] prior_mem [MAX_ROWS];
	logic [1:0] prior_rd_q;
	logic       fwd_hit_q;
	logic [1:0] fwd_data_q;
	logic       prior_re;
	logic       prior_we;
	logic [1:0] prior_wdata;
	logic [1:0] old0;

	logic [1:0] win1_q;
	logic [1:0] win2_q;
	logic       rec0_q;
	logic       rec1_q;

	logic [LUT_AW-1:0] idx_a;
	logic [LUT_AW-1:0] idx_b;
	lut_req_t          lut_req;
	logic              lut_a;
	logic              lut_b;
	push_t             push;
	logic              obuf_room;

	// The whole pipeline moves together whenever the output buffer can take a
	// pair of results; nothing in front of it ever waits on anything else.
	assign pipe_en   = obuf_room;
	assign in_ready  = pipe_en;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign cfg_hit   = (cfg_index == CFG_IDX_ROWS) || (cfg_index == CFG_IDX_COLS);

	// Pixels and padding items both advance the position; padding counts as zero.
	always_comb begin
		adv0 = 1'b0;
		cur0 = 1'b0;
		unique case (in_data.action)
			ACT_PIXEL: begin
				adv0 = 1'b1;
				cur0 = in_data.pixel_in;
			end
			ACT_PAD: begin
				adv0 = 1'b1;
			end
			ACT_LOAD, ACT_NONE: begin
				adv0 = 1'b0;
			end
			default: begin
				adv0 = 1'b0;
			end
		endcase
	end

	assign last0 = (CFG_W'(row_q) + CFG_W'(1)) >= rows_q;

	// A write to a known register restarts the frame; other indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= CFG_W'(RESET_ROWS);
			cols_q <= CFG_W'(RESET_COLS);
			row_q  <= '0;
			col_q  <= '0;
		end else if (cfg_fire && cfg_hit) begin
			if (cfg_index == CFG_IDX_ROWS) begin
				rows_q <= clamp_size(cfg_data, CFG_W'(MAX_ROWS));
			end else begin
				cols_q <= clamp_size(cfg_data, CFG_W'(MAX_COLS));
			end
			row_q <= '0;
			col_q <= '0;
		end else if (in_fire && adv0) begin
			if (last0) begin
				row_q <= '0;
				// After the padding column the next image starts at column zero.
				col_q <= (CFG_W'(col_q) >= cols_q) ? '0 : col_q + COL_W'(1);
			end else begin
				row_q <= row_q + ROW_W'(1);
			end
		end
	end

	// Stage one control. A result for the row above needs a row above; the last
	// row also gives its own result. Column zero gives nothing yet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adv_s1    <= 1'b0;
			load_s1   <= 1'b0;
			emit_a_s1 <= 1'b0;
			emit_b_s1 <= 1'b0;
		end else if (pipe_en) begin
			adv_s1    <= in_fire && adv0;
			load_s1   <= in_fire && (in_data.action == ACT_LOAD);
			emit_a_s1 <= (col_q != '0) && (row_q != '0);
			emit_b_s1 <= (col_q != '0) && last0;
		end
	end

	// Stage one payload. The output column is one behind the arriving column;
	// the left neighbour column exists unless that is column zero, the right one
	// unless the arriving item belongs to the padding column.
	always_ff @(posedge clk) begin
		if (pipe_en) begin
			cur_s1   <= cur0;
			row_s1   <= row_q;
			col_s1   <= POS_W'(col_q - COL_W'(1));
			left_s1  <= col_q != COL_W'(1);
			right_s1 <= CFG_W'(col_q) < cols_q;
			ge1_s1   <= row_q != '0;
			ge2_s1   <= row_q >= ROW_W'(2);
			tidx_s1  <= in_data.table_index;
			tval_s1  <= in_data.table_value;
		end
	end

	// Column store. The read happens on the input transfer, the write back when
	// the item leaves stage one. With a one-row image the next pixel reads the
	// entry in the very cycle it is written, so that write is forwarded.
	assign prior_re    = in_fire && adv0;
	assign prior_we    = pipe_en && adv_s1;
	assign old0        = fwd_hit_q ? fwd_data_q : prior_rd_q;
	assign prior_wdata = {old0[0], cur_s1};

	always_ff @(posedge clk) begin
		if (prior_we) begin
			prior_mem[row_s1] <= prior_wdata;
		end
		if (prior_re) begin
			prior_rd_q <= prior_mem[row_q];
			fwd_data_q <= prior_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q <= 1'b0;
		end else if (prior_re) begin
			fwd_hit_q <= prior_we && (row_s1 == row_q);
		end
	end

	// Window of the two rows above in the current column. Stale contents at the
	// top of a column are masked by the row checks below.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win1_q <= '0;
			win2_q <= '0;
			rec0_q <= 1'b0;
			rec1_q <= 1'b0;
		end else if (pipe_en && adv_s1) begin
			win1_q <= old0;
			win2_q <= win1_q;
			rec0_q <= cur_s1;
			rec1_q <= rec0_q;
		end
	end

	// Table index bit 3*column + row, column 0 being the left neighbour column.
	// Result A is centred on the row above the arriving pixel, result B on the
	// arriving (last) row itself, whose row below lies outside the image.
	always_comb begin
		idx_a[0] = left_s1 && ge2_s1 && win2_q[1];
		idx_a[1] = left_s1 && win1_q[1];
		idx_a[2] = left_s1 && old0[1];
		idx_a[3] = ge2_s1 && win2_q[0];
		idx_a[4] = win1_q[0];
		idx_a[5] = old0[0];
		idx_a[6] = right_s1 && ge2_s1 && rec1_q;
		idx_a[7] = right_s1 && rec0_q;
		idx_a[8] = right_s1 && cur_s1;

		idx_b[0] = left_s1 && ge1_s1 && win1_q[1];
		idx_b[1] = left_s1 && old0[1];
		idx_b[2] = 1'b0;
		idx_b[3] = ge1_s1 && win1_q[0];
		idx_b[4] = old0[0];
		idx_b[5] = 1'b0;
		idx_b[6] = right_s1 && ge1_s1 && rec0_q;
		idx_b[7] = right_s1 && cur_s1;
		idx_b[8] = 1'b0;
	end

	// Loads and lookups both act on the table in stage one, so they stay in
	// stream order.
	assign lut_req = '{
		we:      pipe_en && load_s1,
		waddr:   tidx_s1,
		wdata:   tval_s1,
		re:      pipe_en && adv_s1,
		raddr_a: idx_a,
		raddr_b: idx_b
	};

	bnlf_lut u_lut (
		.clk     (clk),
		.req     (lut_req),
		.rdata_a (lut_a),
		.rdata_b (lut_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_a_s2 <= 1'b0;
			emit_b_s2 <= 1'b0;
		end else if (pipe_en) begin
			emit_a_s2 <= adv_s1 && emit_a_s1;
			emit_b_s2 <= adv_s1 && emit_b_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			row_s2 <= row_s1;
			col_s2 <= col_s1;
		end
	end

	// Result A goes first; it is marked last only when no result B follows.
	assign push = '{
		a_en: pipe_en && emit_a_s2,
		a:    '{pixel_out: lut_a,
			out_row:  POS_W'(row_s2 - ROW_W'(1)),
			out_col:  col_s2,
			run_last: !emit_b_s2},
		b_en: pipe_en && emit_b_s2,
		b:    '{pixel_out: lut_b,
			out_row:  POS_W'(row_s2),
			out_col:  col_s2,
			run_last: 1'b1}
	};

	bnlf_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (obuf_room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

[src/bnlf_check.sv]
// Port-level checks for the binary neighbourhood lookup filter, bound to the
// top level. Uses bnlf_pkg for the result struct.
`timescale 1ns / 1ps
`default_nettype none

module bnlf_check (
	input logic                clk,
	input logic                arst_n,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input bnlf_pkg::out_item_t out_data
);
	import bnlf_pkg::*;

	// A waiting result holds until it is transferred.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed or vanished while stalled");

	// With nothing buffered the input side must be open.
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty output buffer");

	// A result that is not the last of its item is followed at once by the
	// result of the row below in the same column.
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.run_last |=>
			out_valid && out_data.run_last &&
			out_data.out_col == $past(out_data.out_col) &&
			out_data.out_row == $past(out_data.out_row) + 10'd1)
		else $error("second result of a pair missing or misplaced");

	// Under reset no result is offered and the input side is open.
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !out_valid && in_ready)
		else $error("block not idle under reset");

endmodule

bind binary_neighbourhood_lut_filter bnlf_check u_bnlf_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire

[test/binary_neighbourhood_lut_filter_tb.sv]
// Self-checking testbench for binary_neighbourhood_lut_filter.
// It needs bnlf_pkg (payload structs, action codes, register indexes) and the filter RTL.
// A behavioural predictor checks every result against a queue of results still due.
`timescale 1ns / 1ps

module binary_neighbourhood_lut_filter_tb;
	import bnlf_pkg::*;

	localparam int HALF_PERIOD   = 2;
	localparam int RESET_CYCLES  = 12;
	localparam int CYCLE_LIMIT   = 1_000_000;
	// This pause lets table loads in flight finish; they leave nothing in the result queue to wait on.
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_SHOWN     = 10;
	localparam int PHASE_ITEMS   = 200;
	localparam int LONG_HOLD     = 400;
	// Width of the one-row image sent while the receiver holds off.
	localparam int HOLD_COLS     = 64;
	// A script row whose results come from the predictor rather than being typed in.
	localparam int FROM_PREDICTOR = -1;
	localparam out_item_t NO_RES = '0;
	// Register indexes that name no register.
	localparam logic [CFG_IDX_W-1:0] SPARE_IDX_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] SPARE_IDX_HI = 2'd3;

	typedef enum bit {ROW_ITEM, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [CFG_W-1:0]     reg_val;
		in_item_t             item;
		int                   n;
		out_item_t            r0;
		out_item_t            r1;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b1;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	in_item_t             in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_item_t            out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	always #(HALF_PERIOD) clk = ~clk;

	binary_neighbourhood_lut_filter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// ------------------------------------------------------------------
	// Predictor state: its own copy of the lookup table, the two previous
	// columns per row, the two pixels above in the current column, the
	// stream position and the configured image size.
	// ------------------------------------------------------------------
	bit       lut_bits [LUT_DEPTH];
	bit [1:0] col_hist [MAX_ROWS];
	bit [1:0] above = '0;
	int       row_at = 0;
	int       col_at = 0;
	int       n_rows = MAX_ROWS;
	int       n_cols = MAX_COLS;

	// Results worked out for the transfer being predicted, in output order.
	out_item_t step_res [2];
	int        step_n;

	// Results still due from the block, oldest first.
	out_item_t due_q [$];

	int        fault_count = 0;
	int        cycle_count = 0;
	int        sent_count = 0;
	int        send_idle_pct = 0;
	int        stall_pct = 0;
	int        hold_req = 0;
	int        hold_left = 0;
	bit        typed_on = 1'b0;
	stim_row_t typed_row;
	stim_row_t script [$];

	function automatic int clip_size(input int v, input int lim);
		if (v == 0)
			return 1;
		if (v > lim)
			return lim;
		return v;
	endfunction

	function automatic out_item_t spot(input int px, input int r, input int c,
			input int last_one);
		out_item_t o;
		o.pixel_out = 1'(px);
		o.out_row   = POS_W'(r);
		o.out_col   = POS_W'(c);
		o.run_last  = 1'(last_one);
		return o;
	endfunction

	// Pixel at row rr of the left (0), middle (1) or right (2) column of the window,
	// seen while row i of the current column arrives carrying cur. Rows outside the
	// image read as zero.
	function automatic bit pixel_at(input int rr, input int co, input int i, input bit cur);
		if (rr < 0 || rr >= n_rows)
			return 1'b0;
		if (co == 2) begin
			if (rr == i)
				return cur;
			if (rr == i - 1)
				return above[0];
			if (rr == i - 2)
				return above[1];
			return 1'b0;
		end
		if (co == 1)
			return col_hist[rr][0];
		return col_hist[rr][1];
	endfunction

	// Table bit for the neighbourhood of (r,c). The left column does not exist at
	// column zero and the right one does not exist at the last image column.
	function automatic bit filter_at(input int r, input int c, input int i, input bit cur);
		logic [LUT_AW-1:0] idx;
		int                co;
		int                ro;
		idx = '0;
		for (co = 0; co < 3; co++) begin
			if (!(co == 0 && c == 0) && !(co == 2 && c + 1 >= n_cols)) begin
				for (ro = 0; ro < 3; ro++) begin
					if (pixel_at(r + ro - 1, co, i, cur))
						idx[co * 3 + ro] = 1'b1;
				end
			end
		end
		return lut_bits[idx];
	endfunction

	function automatic void shift_row(input int k, input bit v);
		if (k >= 0 && k < MAX_ROWS)
			col_hist[k] = {col_hist[k][0], v};
	endfunction

	// Advances the predictor by one accepted input transfer and leaves the results in
	// step_res. Table loads and the spare action move nothing along.
	function automatic void predict_item(input in_item_t it);
		bit cur;
		int i;
		int j;
		bit last_row;
		step_n = 0;
		if (it.action == ACT_LOAD) begin
			lut_bits[it.table_index] = it.table_value;
		end else if (it.action != ACT_NONE) begin
			// A padding item always counts as a zero pixel.
			cur = (it.action == ACT_PIXEL) ? it.pixel_in : 1'b0;
			i = row_at;
			j = col_at;
			last_row = (row_at + 1 >= n_rows);
			// Output lags one row and one column; the bottom row also closes its own
			// pixel, so that transfer gives two results.
			if (j >= 1) begin
				if (i >= 1) begin
					step_res[step_n] = spot(int'(filter_at(i - 1, j - 1, i, cur)),
						i - 1, j - 1, 0);
					step_n++;
				end
				if (last_row) begin
					step_res[step_n] = spot(int'(filter_at(i, j - 1, i, cur)), i, j - 1, 0);
					step_n++;
				end
				if (step_n > 0)
					step_res[step_n - 1].run_last = 1'b1;
			end
			if (i >= 2)
				shift_row(i - 2, above[1]);
			if (last_row) begin
				if (i >= 1)
					shift_row(i - 1, above[0]);
				shift_row(i, cur);
				above = '0;
				row_at = 0;
				// After the padding column the next image starts again at column zero.
				col_at = (j >= n_cols) ? 0 : j + 1;
			end else begin
				above = {above[0], cur};
				row_at++;
			end
		end
	endfunction

	// Any write to a known register restarts the frame; other indexes are ignored.
	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] val);
		if (idx == CFG_IDX_ROWS || idx == CFG_IDX_COLS) begin
			if (idx == CFG_IDX_ROWS)
				n_rows = clip_size(int'(val), MAX_ROWS);
			else
				n_cols = clip_size(int'(val), MAX_COLS);
			row_at = 0;
			col_at = 0;
			above = '0;
		end
	endfunction

	task automatic note_bad(input string what, input out_item_t want, input out_item_t got);
		fault_count++;
		if (fault_count <= MAX_SHOWN)
			$display("cycle %0d: %s: expected pix %0b row %0d col %0d last %0b, got pix %0b row %0d col %0d last %0b",
				cycle_count, what, want.pixel_out, want.out_row, want.out_col, want.run_last,
				got.pixel_out, got.out_row, got.out_col, got.run_last);
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (due_q.size() == 0) begin
			note_bad("result with nothing outstanding", NO_RES, got);
		end else begin
			want = due_q.pop_front();
			if (want.pixel_out !== got.pixel_out || want.out_row !== got.out_row ||
					want.out_col !== got.out_col || want.run_last !== got.run_last)
				note_bad("result differs", want, got);
		end
	endtask

	// ------------------------------------------------------------------
	// Monitor. Everything is sampled at the rising edge; the inputs only
	// move at the falling edge, so the sampled values are settled. The
	// cycle counter doubles as the watchdog.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("binary_neighbourhood_lut_filter regression: fail");
			$finish;
		end else if (arst_n) begin
			if (out_valid && out_ready)
				check_result(out_data);
			if (cfg_valid && cfg_ready)
				apply_reg(cfg_index, cfg_data);
			if (in_valid && in_ready) begin
				predict_item(in_data);
				// Script rows with typed-in results still advance the predictor state,
				// but the typed values are what the block is held to.
				if (typed_on && typed_row.n != FROM_PREDICTOR) begin
					if (typed_row.n > 0)
						due_q.push_back(typed_row.r0);
					if (typed_row.n > 1)
						due_q.push_back(typed_row.r1);
				end else begin
					if (step_n > 0)
						due_q.push_back(step_res[0]);
					if (step_n > 1)
						due_q.push_back(step_res[1]);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver. Stalls at random by stall_pct. A long hold requested by the
	// stimulus is counted down here, cycle by cycle.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Sender tasks. All of them are entered and left at a falling edge.
	// in_valid is left high after a transfer so that back-to-back items
	// need no gap; drain_results lowers it before a pause, send_item during its idle gaps.
	// ------------------------------------------------------------------
	task automatic send_item(input in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Stops offering items and waits until every result due has arrived, then lets
	// a table load still in flight finish.
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (due_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(val);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic int pick_size();
		int roll;
		roll = $urandom_range(19);
		if (roll == 0)
			return 0;
		if (roll < 3)
			return $urandom_range(7, 40);
		return $urandom_range(1, 6);
	endfunction

	// Sends one frame at the current size: every image column in column-major order,
	// then the padding column. Now and then a table load or a spare-action item is
	// slipped in, a pixel item is sent as padding or padding as a pixel, or the sender waits for
	// the block to empty. A cut below the full length abandons the frame early.
	task automatic run_frame(input int density, input int cut);
		in_item_t it;
		int       r;
		int       c;
		int       left;
		left = cut;
		for (c = 0; c <= n_cols && left > 0; c++) begin
			for (r = 0; r < n_rows && left > 0; r++) begin
				if ($urandom_range(99) < 6) begin
					it.action      = $urandom_range(1) ? ACT_NONE : ACT_LOAD;
					it.pixel_in    = 1'($urandom_range(1));
					it.table_index = LUT_AW'($urandom);
					it.table_value = 1'($urandom_range(1));
					send_item(it);
					if (it.action == ACT_LOAD)
						sent_count++;
				end
				if ($urandom_range(199) == 0)
					drain_results();
				it.action = (c == n_cols) ? ACT_PAD : ACT_PIXEL;
				if ($urandom_range(99) < 4)
					it.action = (it.action == ACT_PIXEL) ? ACT_PAD : ACT_PIXEL;
				it.pixel_in    = ($urandom_range(99) < density);
				it.table_index = LUT_AW'($urandom);
				it.table_value = 1'($urandom_range(1));
				send_item(it);
				sent_count++;
				left--;
			end
		end
	endtask

	function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx, input int val);
		stim_row_t s;
		s = '{kind: ROW_REG, reg_idx: idx, reg_val: CFG_W'(val), item: '0, n: 0,
			r0: NO_RES, r1: NO_RES};
		return s;
	endfunction

	function automatic stim_row_t item_row(input action_t act, input int px,
			input int idx, input int val, input int n, input out_item_t r0,
			input out_item_t r1);
		stim_row_t s;
		s.kind              = ROW_ITEM;
		s.reg_idx           = '0;
		s.reg_val           = '0;
		s.item.action       = act;
		s.item.pixel_in     = 1'(px);
		s.item.table_index  = LUT_AW'(idx);
		s.item.table_value  = 1'(val);
		s.n                 = n;
		s.r0                = r0;
		s.r1                = r1;
		return s;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus.
	// ------------------------------------------------------------------
	initial begin
		in_item_t it;
		int       k;
		int       phase;
		int       phase_start;
		int       pick;
		int       density;
		int       frame_len;

		arst_n <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Every table entry is written before any lookup can reach it. Each entry
		// copies the centre bit of its index, so the filter starts out as the identity
		// and the script below can be read off the input pixels.
		for (k = 0; k < LUT_DEPTH; k++) begin
			it.action      = ACT_LOAD;
			it.pixel_in    = 1'($urandom_range(1));
			it.table_index = LUT_AW'(k);
			it.table_value = k[4];
			send_item(it);
		end

		// Directed script. Straight after reset the image is 1024 x 1024, so the first
		// pixel gives nothing; the spare action is ignored with all fields high.
		script.push_back(item_row(ACT_PIXEL, 1, 0, 0, 0, NO_RES, NO_RES));
		script.push_back(item_row(ACT_NONE, 1, 511, 1, 0, NO_RES, NO_RES));
		// An oversized row count saturates, a zero column count becomes one, and
		// writes to the unused indexes change nothing.
		script.push_back(reg_row(CFG_IDX_ROWS, 2047));
		script.push_back(reg_row(CFG_IDX_COLS, 0));
		script.push_back(reg_row(SPARE_IDX_LO, 2047));
		script.push_back(reg_row(SPARE_IDX_HI, 0));
		// One row, one column: the padding item closes the only pixel, then the
		// position wraps back to column zero.
		script.push_back(reg_row(CFG_IDX_ROWS, 0));
		script.push_back(item_row(ACT_PIXEL, 1, 0, 0, 0, NO_RES, NO_RES));
		script.push_back(item_row(ACT_PAD, 1, 0, 0, 1, spot(1, 0, 0, 1), NO_RES));
		// Single-row image at the widest setting: one result per item from column one.
		script.push_back(reg_row(CFG_IDX_COLS, 1024));
		script.push_back(item_row(ACT_PIXEL, 0, 0, 0, 0, NO_RES, NO_RES));
		script.push_back(item_row(ACT_PIXEL, 1, 0, 0, 1, spot(0, 0, 0, 1), NO_RES));
		script.push_back(item_row(ACT_PIXEL, 1, 0, 0, 1, spot(1, 0, 1, 1), NO_RES));
		// A 3 x 2 image with its padding column, then wrap into the next image.
		script.push_back(reg_row(CFG_IDX_ROWS, 3));
		script.push_back(reg_row(CFG_IDX_COLS, 2));
		script.push_back(item_row(ACT_PIXEL, 1, 0, 0, 0, NO_RES, NO_RES));
		script.push_back(item_row(ACT_PIXEL, 0, 0, 0, 0, NO_RES, NO_RES));
		script.push_back(item_row(ACT_PIXEL, 1, 0, 0, 0, NO_RES, NO_RES));
		script.push_back(item_row(ACT_PIXEL, 0, 0, 0, 0, NO_RES, NO_RES));
		script.push_back(item_row(ACT_PIXEL, 1, 0, 0, 1, spot(1, 0, 0, 1), NO_RES));
		script.push_back(item_row(ACT_PIXEL, 1, 0, 0, 2, spot(0, 1, 0, 0), spot(1, 2, 0, 1)));
		script.push_back(item_row(ACT_PAD, 1, 0, 0, 0, NO_RES, NO_RES));
		script.push_back(item_row(ACT_PAD, 1, 0, 0, 1, spot(0, 0, 1, 1), NO_RES));
		script.push_back(item_row(ACT_PAD, 1, 0, 0, 2, spot(1, 1, 1, 0), spot(1, 2, 1, 1)));
		script.push_back(item_row(ACT_PIXEL, 1, 0, 0, 0, NO_RES, NO_RES));
		// Both end entries of the table, then a restart in mid-column. Padding items
		// in an image column count as zero pixels, so column zero is all clear and
		// every neighbourhood lands on entry zero.
		script.push_back(item_row(ACT_LOAD, 0, 0, 1, 0, NO_RES, NO_RES));
		script.push_back(item_row(ACT_LOAD, 1, 511, 0, 0, NO_RES, NO_RES));
		script.push_back(reg_row(CFG_IDX_COLS, 3));
		script.push_back(item_row(ACT_PAD, 1, 0, 0, 0, NO_RES, NO_RES));
		script.push_back(item_row(ACT_PAD, 1, 0, 0, 0, NO_RES, NO_RES));
		script.push_back(item_row(ACT_PAD, 1, 0, 0, 0, NO_RES, NO_RES));
		script.push_back(item_row(ACT_PIXEL, 0, 0, 0, 0, NO_RES, NO_RES));
		script.push_back(item_row(ACT_PIXEL, 0, 0, 0, 1, spot(1, 0, 0, 1), NO_RES));
		script.push_back(item_row(ACT_PIXEL, 0, 0, 0, 2, spot(1, 1, 0, 0), spot(1, 2, 0, 1)));

		foreach (script[k]) begin
			if (script[k].kind == ROW_REG) begin
				write_reg(script[k].reg_idx, int'(script[k].reg_val));
			end else begin
				typed_row = script[k];
				typed_on = 1'b1;
				send_item(script[k].item);
				typed_on = 1'b0;
			end
		end

		// Random part in four idling regimes: none, sender mostly idle, receiver
		// mostly stalled, and both idling a third of the time.
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 88;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 88;
				end
				default: begin
					send_idle_pct = 33;
					stall_pct = 33;
				end
			endcase
			if (phase == 0) begin
				// One-row image, so every item from column one on gives a result. The
				// receiver holds off for a long stretch while the frame is offered, so
				// the output buffer fills and the block has to refuse input transfers.
				write_reg(CFG_IDX_ROWS, 1);
				write_reg(CFG_IDX_COLS, HOLD_COLS);
				@(posedge clk);
				hold_req = LONG_HOLD;
				@(negedge clk);
				run_frame(50, n_rows * (n_cols + 1));
			end
			phase_start = sent_count;
			while (sent_count - phase_start < PHASE_ITEMS) begin
				// At least one register is written per frame, which also restarts any
				// frame that was abandoned part way.
				pick = $urandom_range(3);
				if (pick != 2)
					write_reg(CFG_IDX_ROWS, pick_size());
				if (pick != 1)
					write_reg(CFG_IDX_COLS, pick_size());
				case ($urandom_range(4))
					0: density = 0;
					1: density = 100;
					2: density = $urandom_range(100);
					default: density = 50;
				endcase
				frame_len = n_rows * (n_cols + 1);
				if ($urandom_range(6) == 0)
					frame_len = $urandom_range(1, frame_len);
				run_frame(density, frame_len);
			end
		end

		// Wind down: let everything due arrive, give the block time to show any
		// stray result, then count whatever never came.
		drain_results();
		while (due_q.size() != 0)
			note_bad("result never arrived", due_q.pop_front(), NO_RES);
		if (fault_count == 0) begin
			$display("binary_neighbourhood_lut_filter regression: pass");
		end else begin
			$display("binary_neighbourhood_lut_filter regression: fail");
		end
		$finish;
	end

endmodule

[filelist.f]
src/bnlf_pkg.sv
src/bnlf_lut.sv
src/bnlf_obuf.sv
src/binary_neighbourhood_lut_filter.sv
src/bnlf_check.sv
test/binary_neighbourhood_lut_filter_tb.sv
